// ===== src/assert_macros.svh =====
// Assertion macros shared by the wavetable oscillator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define WTO_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WTO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/wto_pkg.sv =====
// Shared constants, codes and types of the wavetable oscillator.
package wto_pkg;

   localparam int TABLE_DEPTH     = 16384;
   localparam int TBL_AW          = $clog2(TABLE_DEPTH);
   localparam int BLOCK_SAMPLES   = 128;
   localparam int BLK_W           = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_SAMPLES - 1);
   localparam int LOOKAHEAD_TICKS = 128;

   localparam int SAMPLE_W        = 16;
   localparam int ADDR_IN_W       = 14;
   localparam int MODE_W          = 2;
   localparam int PITCH_W         = 24;
   localparam int PITCH_FRAC_W    = 16;
   localparam int PITCH_INT_W     = PITCH_W - PITCH_FRAC_W;
   localparam int PHASE_W         = 11;
   localparam int WIN_SIZE_W      = 12;
   localparam int WIN_INDEX_W     = 9;
   localparam int TBL_LEN_W       = 15;
   localparam int GLIDE_STEPS_W   = 16;
   localparam int GLIDE_CNT_W     = GLIDE_STEPS_W + 1;
   localparam int BASE_W          = WIN_SIZE_W + WIN_INDEX_W;
   localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_MAX = WIN_SIZE_W'(2048);

   // Interpolation weight keeps the top 14 fraction bits.
   localparam int INTERP_SHIFT    = 14;
   localparam int FRAC_DROP       = PITCH_FRAC_W - INTERP_SHIFT;
   localparam int PROD_W          = INTERP_SHIFT + 1 + SAMPLE_W + 1;

   // Look-ahead check scaled down by the tick count (exact, both sides divide).
   localparam int LA_SHIFT        = PITCH_FRAC_W - $clog2(LOOKAHEAD_TICKS);
   localparam int AHEAD_W         = BASE_W + LA_SHIFT;

   localparam int CSR_AW          = 3;
   localparam int CSR_DW          = 24;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_START = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_WIN_SIZE    = 3'd0,
      CSR_WIN_INDEX   = 3'd1,
      CSR_TBL_LEN     = 3'd2,
      CSR_GLIDE_STEPS = 3'd3,
      CSR_GLIDE_STEP  = 3'd4
   } csr_index_type;

   // Tick issued to the interpolation pipe, aligned with the table read.
   typedef struct packed {
      logic                    valid;
      logic                    interp;
      logic [INTERP_SHIFT-1:0] frac;
   } tick_type;

endpackage

// ===== src/wto_table_ram.sv =====
// Sample table: one write port, two registered read ports.
module wto_table_ram #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/wto_tick_ctrl.sv =====
// Config registers, pitch/glide/phase state and table address generation.
module wto_tick_ctrl import wto_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata,
   input  logic                acc,
   input  logic [MODE_W-1:0]   mode,
   input  logic [PITCH_W-1:0]  start_pitch,
   output logic [TBL_AW-1:0]   rd_addr_cur,
   output logic [TBL_AW-1:0]   rd_addr_nxt,
   output tick_type            tick
);

`include "assert_macros.svh"

   logic [WIN_SIZE_W-1:0]    win_size_ff, win_size_in;
   logic [WIN_INDEX_W-1:0]   win_index_ff, win_index_in;
   logic [TBL_LEN_W-1:0]     tbl_len_ff, tbl_len_in;
   logic [GLIDE_STEPS_W-1:0] glide_steps_ff, glide_steps_in;
   logic [PITCH_W-1:0]       glide_step_ff, glide_step_in;
   logic [BASE_W-1:0]        base_ff, base_in;

   logic [PHASE_W-1:0]       phase_whole_ff, phase_whole_in;
   logic [PITCH_FRAC_W-1:0]  phase_frac_ff, phase_frac_in;
   logic [PITCH_W-1:0]       pitch_ff, pitch_in;
   logic [GLIDE_CNT_W-1:0]   glide_cnt_ff, glide_cnt_in;
   logic                     playing_ff, playing_in;
   logic                     interp_ff, interp_in;
   logic [BLK_W-1:0]         blk_pos_ff, blk_pos_in;

   logic [WIN_SIZE_W-1:0]    ws_eff, ws_new_eff;
   logic [BASE_W-1:0]        pos_cur, pos_nxt;
   logic [WIN_SIZE_W-1:0]    whole_nxt;
   logic [AHEAD_W-1:0]       ahead, room;
   logic                     la_ok, interp_now;
   logic                     glide_act;
   logic signed [PITCH_W+1:0] pitch_sum;
   logic [PITCH_W-1:0]       pitch_gl, pitch_use;
   logic [PITCH_FRAC_W:0]    frac_sum;
   logic [WIN_SIZE_W-1:0]    whole_sum;
   logic                     tick_go;

   // Register writes
   always_comb begin
      win_size_in    = win_size_ff;
      win_index_in   = win_index_ff;
      tbl_len_in     = tbl_len_ff;
      glide_steps_in = glide_steps_ff;
      glide_step_in  = glide_step_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIN_SIZE:    win_size_in    = csr_wdata[WIN_SIZE_W-1:0];
            CSR_WIN_INDEX:   win_index_in   = csr_wdata[WIN_INDEX_W-1:0];
            CSR_TBL_LEN:     tbl_len_in     = csr_wdata[TBL_LEN_W-1:0];
            CSR_GLIDE_STEPS: glide_steps_in = csr_wdata[GLIDE_STEPS_W-1:0];
            CSR_GLIDE_STEP:  glide_step_in  = csr_wdata[PITCH_W-1:0];
            default: begin
            end
         endcase
      end
      ws_new_eff = (win_size_in > WIN_SIZE_MAX) ? WIN_SIZE_MAX : win_size_in;
      // Window base follows the registers in the same cycle as the write.
      base_in    = BASE_W'(ws_new_eff) * BASE_W'(win_index_in);
   end

   // Addresses and block-start look-ahead
   always_comb begin
      ws_eff     = (win_size_ff > WIN_SIZE_MAX) ? WIN_SIZE_MAX : win_size_ff;
      pos_cur    = base_ff + BASE_W'(phase_whole_ff);
      whole_nxt  = WIN_SIZE_W'(phase_whole_ff) + WIN_SIZE_W'(1);
      if (whole_nxt >= ws_eff) begin
         whole_nxt = '0;
      end
      pos_nxt    = base_ff + BASE_W'(whole_nxt);
      ahead      = {pos_cur, {LA_SHIFT{1'b0}}} + AHEAD_W'(pitch_ff[PITCH_FRAC_W-1:0]);
      room       = AHEAD_W'({tbl_len_ff, {LA_SHIFT{1'b0}}});
      la_ok      = (pitch_ff[PITCH_W-1:PITCH_FRAC_W] == '0) && (ahead < room);
      interp_now = (blk_pos_ff == '0) ? la_ok : interp_ff;
   end

   // Glide with saturation, then phase advance
   always_comb begin
      glide_act = (glide_steps_ff != '0) && (glide_cnt_ff <= GLIDE_CNT_W'(glide_steps_ff));
      pitch_sum = $signed({2'b00, pitch_ff})
                + $signed({{2{glide_step_ff[PITCH_W-1]}}, glide_step_ff});
      if (pitch_sum[PITCH_W+1]) begin
         pitch_gl = '0;
      end else if (pitch_sum[PITCH_W]) begin
         pitch_gl = '1;
      end else begin
         pitch_gl = pitch_sum[PITCH_W-1:0];
      end
      pitch_use = glide_act ? pitch_gl : pitch_ff;
      frac_sum  = {1'b0, phase_frac_ff} + {1'b0, pitch_use[PITCH_FRAC_W-1:0]};
      whole_sum = WIN_SIZE_W'(phase_whole_ff) + WIN_SIZE_W'(pitch_use[PITCH_W-1:PITCH_FRAC_W])
                + WIN_SIZE_W'(frac_sum[PITCH_FRAC_W]);
   end

   // Item decode and next state
   always_comb begin
      phase_whole_in = phase_whole_ff;
      phase_frac_in  = phase_frac_ff;
      pitch_in       = pitch_ff;
      glide_cnt_in   = glide_cnt_ff;
      playing_in     = playing_ff;
      interp_in      = interp_ff;
      blk_pos_in     = blk_pos_ff;
      tick_go        = 1'b0;
      if (acc) begin
         unique case (mode)
            MODE_START: begin
               pitch_in       = start_pitch;
               phase_whole_in = '0;
               phase_frac_in  = '0;
               glide_cnt_in   = '0;
               playing_in     = 1'b1;
               blk_pos_in     = '0;
            end
            MODE_TICK: begin
               if (playing_ff) begin
                  tick_go   = 1'b1;
                  interp_in = interp_now;
                  if (glide_act) begin
                     pitch_in     = pitch_gl;
                     glide_cnt_in = glide_cnt_ff + GLIDE_CNT_W'(1);
                  end
                  phase_frac_in  = frac_sum[PITCH_FRAC_W-1:0];
                  phase_whole_in = (whole_sum >= ws_eff) ? '0 : whole_sum[PHASE_W-1:0];
                  blk_pos_in     = (blk_pos_ff == BLK_LAST) ? '0 : blk_pos_ff + BLK_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff    <= WIN_SIZE_W'(256);
         win_index_ff   <= '0;
         tbl_len_ff     <= TBL_LEN_W'(16384);
         glide_steps_ff <= '0;
         glide_step_ff  <= '0;
         base_ff        <= '0;
         phase_whole_ff <= '0;
         phase_frac_ff  <= '0;
         pitch_ff       <= '0;
         glide_cnt_ff   <= '0;
         playing_ff     <= 1'b0;
         interp_ff      <= 1'b0;
         blk_pos_ff     <= '0;
      end else begin
         win_size_ff    <= win_size_in;
         win_index_ff   <= win_index_in;
         tbl_len_ff     <= tbl_len_in;
         glide_steps_ff <= glide_steps_in;
         glide_step_ff  <= glide_step_in;
         base_ff        <= base_in;
         phase_whole_ff <= phase_whole_in;
         phase_frac_ff  <= phase_frac_in;
         pitch_ff       <= pitch_in;
         glide_cnt_ff   <= glide_cnt_in;
         playing_ff     <= playing_in;
         interp_ff      <= interp_in;
         blk_pos_ff     <= blk_pos_in;
      end
   end

   assign rd_addr_cur = pos_cur[TBL_AW-1:0];
   assign rd_addr_nxt = pos_nxt[TBL_AW-1:0];

   assign tick.valid  = tick_go;
   assign tick.interp = interp_now;
   assign tick.frac   = phase_frac_ff[PITCH_FRAC_W-1:FRAC_DROP];

   `WTO_ASSERT_NEXT(a_start_clears, acc && (mode == MODE_START), (phase_whole_ff == '0) && (phase_frac_ff == '0) && (blk_pos_ff == '0) && playing_ff, "start left phase or block position set")
   `WTO_ASSERT_NEXT(a_phase_in_window, tick_go, (WIN_SIZE_W'(phase_whole_ff) < $past(ws_eff)) || (phase_whole_ff == '0), "phase left outside the window")

endmodule

// ===== src/wto_interp.sv =====
// Interpolation pipe: difference and multiply, scale and add, output register.
module wto_interp import wto_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  tick_type                   tick,
   input  logic signed [SAMPLE_W-1:0] rd_cur,
   input  logic signed [SAMPLE_W-1:0] rd_nxt,
   output logic                       s1_load,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

`include "assert_macros.svh"

   logic                       s1_v_ff;
   logic                       s1_interp_ff;
   logic [INTERP_SHIFT-1:0]    s1_frac_ff;
   logic                       s2_v_ff;
   logic                       s2_interp_ff;
   logic signed [SAMPLE_W-1:0] s2_cur_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff;
   logic                       out_v_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;

   logic                       o_adv, s2_load;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   term_w;
   logic signed [SAMPLE_W-1:0] res;

   // Each stage moves when the one after it is empty or draining.
   assign o_adv   = !out_v_ff || rsp_ready;
   assign s2_load = !s2_v_ff || o_adv;
   assign s1_load = !s1_v_ff || s2_load;

   always_comb begin
      diff   = $signed({rd_nxt[SAMPLE_W-1], rd_nxt}) - $signed({rd_cur[SAMPLE_W-1], rd_cur});
      // Both operands at full product width; weight is non-negative.
      prod   = $signed({{(PROD_W-INTERP_SHIFT){1'b0}}, s1_frac_ff}) * PROD_W'(diff);
      // Arithmetic shift floors, i.e. rounds toward minus infinity.
      term_w = s2_interp_ff ? (s2_prod_ff >>> INTERP_SHIFT) : '0;
      res    = s2_cur_ff + term_w[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_v_ff <= tick.valid;
         end
         if (s2_load) begin
            s2_v_ff <= s1_v_ff;
         end
         if (o_adv) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_interp_ff <= tick.interp;
         s1_frac_ff   <= tick.frac;
      end
      if (s2_load) begin
         s2_interp_ff <= s1_interp_ff;
         s2_cur_ff    <= rd_cur;
         s2_prod_ff   <= prod;
      end
      if (o_adv) begin
         out_sample_ff <= res;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_sample = out_sample_ff;

   `WTO_ASSERT_NEXT(a_s1_holds, s1_v_ff && !s2_load, s1_v_ff && $stable(s1_frac_ff), "stalled tick lost its slot")
   `WTO_ASSERT_NEXT(a_plain_sample, s2_v_ff && o_adv && !s2_interp_ff, rsp_sample == $past(s2_cur_ff), "non-interpolated sample altered")

endmodule

// ===== src/wavetable_oscillator.sv =====
// Top level of the wavetable oscillator with linear interpolation.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    mode, table_address, table_value, start_pitch
//   rsp_      out        rsp_valid/rsp_ready    sample
//   csr_      in         csr_we (no wait)       csr_index, csr_wdata
//
// One item is taken per cycle while the first pipe stage can load, ticks back to back;
// a tick's table read is at its transfer edge, then its multiply is registered in stage
// two and its scale and add in the output register, which puts its sample on rsp_.
// Both taps of a tick come from one read of the dual-read table RAM.
// A stalled rsp_ holds the output register while two upstream stages still fill.
// Reset is synchronous and clears control state and registers; the table is not cleared.
module wavetable_oscillator import wto_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_AW-1:0]           csr_index,
   input  logic [CSR_DW-1:0]           csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [MODE_W-1:0]           req_mode,
   input  logic [ADDR_IN_W-1:0]        req_table_address,
   input  logic signed [SAMPLE_W-1:0]  req_table_value,
   input  logic [PITCH_W-1:0]          req_start_pitch,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_sample
);

   logic                       req_xfer;
   logic                       tbl_wr;
   logic                       s1_load;
   logic [TBL_AW-1:0]          rd_addr_cur;
   logic [TBL_AW-1:0]          rd_addr_nxt;
   logic [SAMPLE_W-1:0]        rd_cur;
   logic [SAMPLE_W-1:0]        rd_nxt;
   tick_type                   tick;

   // Input is taken whenever the first pipe stage can load.
   assign req_ready = s1_load && !reset;
   assign req_xfer  = req_valid && req_ready;
   // Table word write; a later tick reads it no earlier than the next edge.
   assign tbl_wr    = req_xfer && (req_mode == MODE_WRITE);

   wto_tick_ctrl u_tick_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .acc         (req_xfer),
      .mode        (req_mode),
      .start_pitch (req_start_pitch),
      .rd_addr_cur (rd_addr_cur),
      .rd_addr_nxt (rd_addr_nxt),
      .tick        (tick)
   );

   // Read data only advances with the stage that consumes it.
   wto_table_ram #(
      .ADDR_W (TBL_AW),
      .DATA_W (SAMPLE_W)
   ) u_table_ram (
      .clock     (clock),
      .wr_en     (tbl_wr),
      .wr_addr   (TBL_AW'(req_table_address)),
      .wr_data   (req_table_value),
      .rd_en     (s1_load),
      .rd_addr_a (rd_addr_cur),
      .rd_addr_b (rd_addr_nxt),
      .rd_data_a (rd_cur),
      .rd_data_b (rd_nxt)
   );

   wto_interp u_interp (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .rd_cur     ($signed(rd_cur)),
      .rd_nxt     ($signed(rd_nxt)),
      .s1_load    (s1_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

endmodule

// ===== dv/tb_wavetable_oscillator.sv =====
`timescale 1ns / 1ps
// Testbench of the wavetable oscillator: directed rows, then random notes against a predictor.
module tb_wavetable_oscillator;
   import wto_pkg::*;

   // Mode 3 has no name in the package; the block must drop it.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 3;
   localparam int MAX_IDLE     = 5;
   localparam int HOLD_CYCLES  = 300;      // long receiver hold-off, fills the pipe
   localparam int DRAIN_CYCLES = 16;       // drain wait after the last pending sample
   localparam int RANDOM_ITEMS = 1200;
   localparam int NUM_PHASES   = 7;
   localparam int TIMEOUT_NS   = 5_000_000;

   localparam logic [PITCH_W-1:0] PITCH_ONE = PITCH_W'(1 << PITCH_FRAC_W);
   localparam longint PITCH_TOP = (longint'(1) << PITCH_W) - 1;

   // One input transfer, plus an optional typed-in expected sample.
   typedef struct {
      logic [MODE_W-1:0]          mode;
      logic [ADDR_IN_W-1:0]       addr;
      logic signed [SAMPLE_W-1:0] value;
      logic [PITCH_W-1:0]         pitch;
      bit                         typed;
      logic signed [SAMPLE_W-1:0] want;
   } osc_req_type;

   // ---------------------------------------------------------------------
   // DUT signals, inputs driven to known values from time zero
   // ---------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [CSR_AW-1:0]           csr_index = '0;
   logic [CSR_DW-1:0]           csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [MODE_W-1:0]           req_mode = '0;
   logic [ADDR_IN_W-1:0]        req_table_address = '0;
   logic signed [SAMPLE_W-1:0]  req_table_value = '0;
   logic [PITCH_W-1:0]          req_start_pitch = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_sample;

   wavetable_oscillator dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_table_address (req_table_address),
      .req_table_value   (req_table_value),
      .req_start_pitch   (req_start_pitch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: registers, table and oscillator, as after reset
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
   bit                         word_written [TABLE_DEPTH];
   logic [WIN_SIZE_W-1:0]      reg_win_size    = WIN_SIZE_W'(256);
   logic [WIN_INDEX_W-1:0]     reg_win_index   = '0;
   logic [TBL_LEN_W-1:0]       reg_tbl_len     = TBL_LEN_W'(16384);
   logic [GLIDE_STEPS_W-1:0]   reg_glide_steps = '0;
   logic signed [PITCH_W-1:0]  reg_glide_step  = '0;

   logic [PHASE_W-1:0]         osc_whole     = '0;
   logic [PITCH_FRAC_W-1:0]    osc_frac      = '0;
   logic [PITCH_W-1:0]         osc_pitch     = '0;
   logic [GLIDE_CNT_W-1:0]     osc_glide_cnt = '0;
   bit                         osc_playing   = 1'b0;
   bit                         osc_interp    = 1'b0;
   logic [BLK_W-1:0]           osc_blk_pos   = '0;

   logic signed [SAMPLE_W-1:0] pending_samples [$];
   int                         err_count = 0;
   int                         items_sent = 0;
   bit                         idle_on = 1'b0;
   bit                         hold_request = 1'b0;
   osc_req_type                directed_rows [$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      err_count++;
   endtask

   // Advance the oscillator model by one accepted transfer.
   task automatic advance_oscillator(input osc_req_type it, output bit produced,
                                     output logic signed [SAMPLE_W-1:0] smp);
      int unsigned ws, base, whole, frac, partner_pos;
      longint      ahead, pitch_next, cur, partner, term;
      produced = 1'b0;
      smp      = '0;
      if (it.mode == MODE_WRITE) begin
         wave_mem[it.addr]     = it.value;    // 14-bit address covers the whole table
         word_written[it.addr] = 1'b1;
      end else if (it.mode == MODE_START) begin
         osc_pitch     = it.pitch;
         osc_whole     = '0;
         osc_frac      = '0;
         osc_glide_cnt = '0;
         osc_playing   = 1'b1;
         osc_blk_pos   = '0;
      end else if (it.mode == MODE_TICK && osc_playing) begin
         // oversized windows act as the largest one
         ws   = (reg_win_size > WIN_SIZE_MAX) ? WIN_SIZE_MAX : reg_win_size;
         base = ws * reg_win_index;

         // interpolation decided at block start, on the pitch before glide
         if (osc_blk_pos == '0) begin
            ahead = (longint'(base + osc_whole) << PITCH_FRAC_W)
                  + longint'(osc_pitch) * LOOKAHEAD_TICKS;
            osc_interp = (osc_pitch < PITCH_ONE)
                      && (ahead < (longint'(reg_tbl_len) << PITCH_FRAC_W));
         end

         if (reg_glide_steps != '0 && osc_glide_cnt <= reg_glide_steps) begin
            pitch_next = longint'(osc_pitch) + longint'(reg_glide_step);
            if (pitch_next < 0) pitch_next = 0;
            if (pitch_next > PITCH_TOP) pitch_next = PITCH_TOP;
            osc_pitch     = PITCH_W'(pitch_next);
            osc_glide_cnt = osc_glide_cnt + 1'b1;
         end

         cur  = longint'(wave_mem[(base + osc_whole) % TABLE_DEPTH]);
         term = 0;
         if (osc_interp) begin
            // partner stays in the window: last sample pairs with the first
            partner_pos = osc_whole + 1;
            if (partner_pos >= ws) partner_pos = 0;
            partner = longint'(wave_mem[(base + partner_pos) % TABLE_DEPTH]);
            term    = (longint'(osc_frac >> FRAC_DROP) * (partner - cur)) >>> INTERP_SHIFT;
         end
         smp      = SAMPLE_W'(cur + term);
         produced = 1'b1;

         whole = osc_whole + (osc_pitch >> PITCH_FRAC_W);
         frac  = osc_frac + osc_pitch[PITCH_FRAC_W-1:0];
         if (frac >= (1 << PITCH_FRAC_W)) begin
            frac  = frac - (1 << PITCH_FRAC_W);
            whole = whole + 1;
         end
         if (whole >= ws) whole = 0;           // zero-size window always wraps
         osc_whole   = PHASE_W'(whole);
         osc_frac    = PITCH_FRAC_W'(frac);
         osc_blk_pos = (osc_blk_pos == BLK_LAST) ? '0 : osc_blk_pos + 1'b1;
      end
   endtask

   // Item builders; fields a mode ignores carry random junk.
   function automatic osc_req_type make_req(input logic [MODE_W-1:0] mode);
      osc_req_type it;
      it.mode  = mode;
      it.addr  = ADDR_IN_W'($urandom());
      it.value = SAMPLE_W'($urandom());
      it.pitch = PITCH_W'($urandom());
      it.typed = 1'b0;
      it.want  = '0;
      return it;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: optional gap, hold valid until the transfer, then predict
   // ---------------------------------------------------------------------
   task automatic drive_req(input osc_req_type it);
      int                         gap;
      bit                         produced;
      logic signed [SAMPLE_W-1:0] smp;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= it.mode;
      req_table_address <= it.addr;
      req_table_value   <= it.value;
      req_start_pitch   <= it.pitch;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      advance_oscillator(it, produced, smp);
      if (produced) pending_samples.push_back(it.typed ? it.want : smp);
   endtask

   // A tick never reads a word that was never written: such a word is written first.
   task automatic send_req(input osc_req_type it);
      int unsigned ws, base, partner_pos, addr_cur, addr_partner;
      longint      ahead;
      bit          use_partner;
      osc_req_type wr;
      if (it.mode == MODE_TICK && osc_playing) begin
         ws          = (reg_win_size > WIN_SIZE_MAX) ? WIN_SIZE_MAX : reg_win_size;
         base        = ws * reg_win_index;
         use_partner = osc_interp;
         if (osc_blk_pos == '0) begin
            ahead = (longint'(base + osc_whole) << PITCH_FRAC_W)
                  + longint'(osc_pitch) * LOOKAHEAD_TICKS;
            use_partner = (osc_pitch < PITCH_ONE)
                       && (ahead < (longint'(reg_tbl_len) << PITCH_FRAC_W));
         end
         partner_pos = osc_whole + 1;
         if (partner_pos >= ws) partner_pos = 0;
         addr_cur     = (base + osc_whole) % TABLE_DEPTH;
         addr_partner = (base + partner_pos) % TABLE_DEPTH;
         if (!word_written[addr_cur]) begin
            wr      = make_req(MODE_WRITE);
            wr.addr = ADDR_IN_W'(addr_cur);
            drive_req(wr);
         end
         if (use_partner && !word_written[addr_partner]) begin
            wr      = make_req(MODE_WRITE);
            wr.addr = ADDR_IN_W'(addr_partner);
            drive_req(wr);
         end
      end
      drive_req(it);
   endtask

   function automatic logic [PITCH_W-1:0] rand_pitch();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4, 5: return PITCH_W'($urandom_range(0, PITCH_ONE - 1));  // interpolating
         6, 7:    return PITCH_W'($urandom_range(0, 24'h03FFFF));
         default: return PITCH_W'($urandom());
      endcase
   endfunction

   task automatic send_start();
      osc_req_type it;
      it       = make_req(MODE_START);
      it.pitch = rand_pitch();
      send_req(it);
   endtask

   // ---------------------------------------------------------------------
   // Configuration: only while the block is idle
   // ---------------------------------------------------------------------
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_WIN_SIZE:    reg_win_size    = data[WIN_SIZE_W-1:0];
         CSR_WIN_INDEX:   reg_win_index   = data[WIN_INDEX_W-1:0];
         CSR_TBL_LEN:     reg_tbl_len     = data[TBL_LEN_W-1:0];
         CSR_GLIDE_STEPS: reg_glide_steps = data[GLIDE_STEPS_W-1:0];
         CSR_GLIDE_STEP:  reg_glide_step  = data[PITCH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [WIN_SIZE_W-1:0] ws,
                               input logic [WIN_INDEX_W-1:0] wi,
                               input logic [TBL_LEN_W-1:0] tl,
                               input logic [GLIDE_STEPS_W-1:0] gs,
                               input logic signed [PITCH_W-1:0] gstep);
      write_reg(CSR_WIN_SIZE,    CSR_DW'(ws));
      write_reg(CSR_WIN_INDEX,   CSR_DW'(wi));
      write_reg(CSR_TBL_LEN,     CSR_DW'(tl));
      write_reg(CSR_GLIDE_STEPS, CSR_DW'(gs));
      write_reg(CSR_GLIDE_STEP,  CSR_DW'(gstep));
      csr_we <= 1'b0;
   endtask

   // Wait out every pending sample, then the pipe depth for write/start items.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random part: mostly notes (start + run of ticks), some table updates and noise.
   task automatic run_notes(input int items);
      int start_count, ticks, pick;
      start_count = items_sent;
      while (items_sent - start_count < items) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_start();
            // occasional long notes cross block boundaries
            ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(130, 260)
                                                : $urandom_range(1, 40);
            repeat (ticks) begin
               if ($urandom_range(0, 15) == 0) send_req(make_req(MODE_WRITE));
               else                            send_req(make_req(MODE_TICK));
            end
         end else if (pick < 17) begin
            send_req(make_req(MODE_WRITE));
         end else if (pick < 19) begin
            send_req(make_req(MODE_UNUSED));     // dropped, no sample
         end else begin
            send_req(make_req(MODE_TICK));       // stray tick
         end
      end
   endtask

   task automatic random_config();
      logic [WIN_SIZE_W-1:0]     ws;
      logic [WIN_INDEX_W-1:0]    wi;
      logic [TBL_LEN_W-1:0]      tl;
      logic [GLIDE_STEPS_W-1:0]  gs;
      logic signed [PITCH_W-1:0] gstep;
      ws = ($urandom_range(0, 3) != 0) ? WIN_SIZE_W'($urandom_range(32, 2048))
                                       : WIN_SIZE_W'($urandom());
      // small indexes keep the look-ahead inside the table most of the time
      wi = ($urandom_range(0, 3) != 0) ? WIN_INDEX_W'($urandom_range(0, 7))
                                       : WIN_INDEX_W'($urandom());
      tl = ($urandom_range(0, 1) != 0) ? TBL_LEN_W'(16384) : TBL_LEN_W'($urandom());
      case ($urandom_range(0, 3))
         0:       gs = '0;
         1:       gs = GLIDE_STEPS_W'($urandom());
         default: gs = GLIDE_STEPS_W'($urandom_range(1, 300));
      endcase
      gstep = ($urandom_range(0, 3) != 0) ? PITCH_W'($signed($urandom_range(0, 16'h4000)) - 16'sh2000)
                                          : PITCH_W'($urandom());
      apply_config(ws, wi, tl, gs, gstep);
   endtask

   // Directed rows; typed expectations only where they are obvious.
   task automatic build_directed();
      // tick before any start: no sample
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
      // unused mode with every field at its top value: dropped
      directed_rows.push_back('{MODE_UNUSED, '1,     '1,           '1,        1'b0, '0});
      // pitch zero holds on word 0: extremes of the sample range
      directed_rows.push_back('{MODE_WRITE,  '0,     16'sh7FFF,    '0,        1'b0, '0});
      directed_rows.push_back('{MODE_START,  '0,     '0,           '0,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b1, 16'sh7FFF});
      directed_rows.push_back('{MODE_WRITE,  '0,     -16'sh8000,   '0,        1'b0, '0});
      directed_rows.push_back('{MODE_START,  '0,     '0,           '0,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b1, -16'sh8000});
      // pitch just below one: widest interpolation step between extremes
      directed_rows.push_back('{MODE_WRITE,  14'd1,  16'sh7FFF,    '0,        1'b0, '0});
      directed_rows.push_back('{MODE_START,  '0,     '0,           24'h00FFFF, 1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b1, -16'sh8000});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
      // top address, then the largest pitch: no interpolation, phase wraps
      directed_rows.push_back('{MODE_WRITE,  '1,     -16'sd1,      '0,        1'b0, '0});
      directed_rows.push_back('{MODE_START,  '0,     '0,           '1,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b1, -16'sh8000});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
      directed_rows.push_back('{MODE_WRITE,  14'd255, 16'sd12345,  '0,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
      directed_rows.push_back('{MODE_TICK,   '0,     '0,           '0,        1'b0, '0});
   endtask

   // ---------------------------------------------------------------------
   // Main stimulus
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset register values
      idle_on = 1'b1;
      build_directed();
      foreach (directed_rows[i]) send_req(directed_rows[i]);
      drain_block();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            // 32-sample window
            0: apply_config(12'd32, '0, 15'd16384, '0, '0);
            // largest window at the last index, table length zero,
            // longest glide at the most negative step
            1: apply_config(12'd2048, '1, '0, '1, -24'sd8388608);
            // oversized window, full-range length, short glide at the top step
            2: apply_config('1, 9'd3, '1, 16'd40, 24'sd8388607);
            // zero window: the phase never leaves 0
            3: apply_config('0, 9'd5, 15'd16384, 16'd25, -24'sd4000);
            default: random_config();
         endcase
         idle_on = (ph % 2 == 0);
         if (ph == 2) begin
            // receiver holds off while the sender keeps pushing ticks
            hold_request = 1'b1;
            send_start();
         end
         run_notes(RANDOM_ITEMS / NUM_PHASES);
         drain_block();
      end

      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random stalls, one long hold-off, in-order compare
   // ---------------------------------------------------------------------
   initial begin
      int                         stall;
      logic signed [SAMPLE_W-1:0] want;
      wait (!reset);
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         // transfer taken at this edge; values read are the pre-edge ones
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with nothing pending", rsp_sample));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want)
               report_mismatch($sformatf("sample got %0d want %0d", rsp_sample, want));
         end
      end
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
